// File: hw/rtl/tllsp_pkg.sv
// Shared constants, codes and types for the two-level LRU slot pager.
package tllsp_pkg;

  localparam int HostSlotsDef   = 4;
  localparam int DeviceSlotsDef = 16;
  localparam int KeyHalfDef     = 8;

  localparam int FuncW   = 2;
  localparam int IdxW    = 8;
  localparam int StatusW = 3;
  localparam int DslotW  = 4;
  localparam int HslotW  = 2;
  localparam int PendW   = 3;
  localparam int CountW  = 32;
  localparam int CntCfgW = 9;
  localparam int BytesW  = 40;
  localparam int StampW  = 64;
  localparam int CfgIdxW = 2;

  localparam logic [FuncW-1:0] FUNC_STAGE  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_DRAIN  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_LOCATE = 2'd2;
  localparam logic [FuncW-1:0] FUNC_RSVD   = 2'd3;

  localparam logic [StatusW-1:0] ST_HIT     = 3'd0;
  localparam logic [StatusW-1:0] ST_MISS    = 3'd1;
  localparam logic [StatusW-1:0] ST_OVERLAP = 3'd2;
  localparam logic [StatusW-1:0] ST_SMALL   = 3'd3;
  localparam logic [StatusW-1:0] ST_RANGE   = 3'd4;
  localparam logic [StatusW-1:0] ST_NOTRES  = 3'd5;
  localparam logic [StatusW-1:0] ST_DONE    = 3'd6;

  localparam logic [CfgIdxW-1:0] CFG_LAYERS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXPERTS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_EBYTES  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SBYTES  = 2'd3;

  // Control from sequencer to scan unit
  typedef struct packed {
    logic start;
  } scan_ctl_t;

endpackage

// File: hw/rtl/tllsp_lru_scan.sv
// Shared slot scanner: one slot per cycle, finds first free else least stamp.
module tllsp_lru_scan #(
  parameter int N  = 16,
  parameter int IW = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tllsp_pkg::scan_ctl_t      ctl,
  input  logic                      cur_valid,
  input  logic [tllsp_pkg::StampW-1:0] cur_stamp,
  output logic [IW-1:0]             idx,
  output logic                      done,
  output logic [IW-1:0]             best
);
  import tllsp_pkg::*;

  logic          busy_r, busy_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic [StampW-1:0] bstamp_r, bstamp_nxt;
  logic          free_r, free_nxt;
  logic          last;

  assign last = (idx_r == IW'(N - 1));

  // Compare the current slot against the best so far
  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    best_nxt   = best_r;
    bstamp_nxt = bstamp_r;
    free_nxt   = free_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      free_nxt = 1'b0;
    end else if (busy_r) begin
      if (!free_r) begin
        if (!cur_valid) begin
          free_nxt = 1'b1;
          best_nxt = idx_r;
        end else if (idx_r == '0 || cur_stamp < bstamp_r) begin
          best_nxt   = idx_r;
          bstamp_nxt = cur_stamp;
        end
      end
      if (last) busy_nxt = 1'b0;
      else idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      free_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      free_r <= free_nxt;
    end
    best_r   <= best_nxt;
    bstamp_r <= bstamp_nxt;
  end

  assign idx  = idx_r;
  assign done = busy_r && last;
  assign best = best_nxt;

endmodule

// File: hw/rtl/two_level_lru_slot_pager_unit.sv
// Top level of the two-level LRU slot pager with pending-copy tracking.
// Per request: drain goes straight to the result; locate runs the hit scan; stage runs up to
// the pending check, hit scan, host scan and device scan in that order, the two LRU scans on
// a slot scanner sized to the larger slot count rounded up to a power of two; one slot scanner
// and two key comparators (pending and device); out_stall holds the result.
// One request at a time; in_stall is high from acceptance until the result is taken.
// Synchronous active-low reset clears all valid bits, live marks, counters and stamps.
module two_level_lru_slot_pager_unit #(
  parameter int HOST_SLOT_NUM = tllsp_pkg::HostSlotsDef,
  parameter int DEV_SLOT_NUM  = tllsp_pkg::DeviceSlotsDef,
  parameter int KEY_HALF_BITS = tllsp_pkg::KeyHalfDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tllsp_pkg::FuncW-1:0]    in_func,
  input  logic [tllsp_pkg::IdxW-1:0]     in_layer_index,
  input  logic [tllsp_pkg::IdxW-1:0]     in_expert_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tllsp_pkg::StatusW-1:0]  out_status,
  output logic [tllsp_pkg::DslotW-1:0]   out_device_slot_index,
  output logic [tllsp_pkg::HslotW-1:0]   out_host_slot_index,
  output logic                           out_drained,
  output logic [tllsp_pkg::PendW-1:0]    out_pending_count,
  output logic [tllsp_pkg::CountW-1:0]   out_hit_total,
  output logic [tllsp_pkg::CountW-1:0]   out_miss_total,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tllsp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tllsp_pkg::BytesW-1:0]   cfg_data
);
  import tllsp_pkg::*;

  localparam int KW  = 2 * KEY_HALF_BITS;
  localparam int DW  = (DEV_SLOT_NUM > 1) ? $clog2(DEV_SLOT_NUM) : 1;
  localparam int HW  = (HOST_SLOT_NUM > 1) ? $clog2(HOST_SLOT_NUM) : 1;
  localparam int PW  = $clog2(HOST_SLOT_NUM + 1);
  localparam int SW  = (DW > HW) ? DW : HW;
  localparam int LW  = (KEY_HALF_BITS < IdxW) ? KEY_HALF_BITS : IdxW;

  typedef enum logic [3:0] {
    S_IDLE, S_PEND, S_HITSCAN, S_CHECK, S_HSCAN, S_HWAIT, S_DSCAN, S_DWAIT,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration
  logic [CntCfgW-1:0] layers_r, experts_r;
  logic [BytesW-1:0]  ebytes_r, sbytes_r;

  // Slot state
  logic [KW-1:0]     dkey_r   [DEV_SLOT_NUM];
  logic [DEV_SLOT_NUM-1:0] dvalid_r;
  logic [StampW-1:0] dstamp_r [DEV_SLOT_NUM];
  logic [HOST_SLOT_NUM-1:0] hvalid_r, hlive_r;
  logic [StampW-1:0] hstamp_r [HOST_SLOT_NUM];
  logic [KW-1:0]     pkey_r   [HOST_SLOT_NUM];
  logic [PW-1:0]     pfill_r;
  logic [StampW-1:0] stamp_r;
  logic [CountW-1:0] hits_r, misses_r;

  // Request
  logic [FuncW-1:0]  func_r;
  logic [IdxW-1:0]   layer_r, expert_r;
  logic [KW-1:0]     key;
  logic [HW-1:0]     pidx_r;
  logic [DW-1:0]     hidx_r;
  logic              found_r;
  logic              hscan_r;
  logic [HW-1:0]     hsel_r;

  // Result
  logic [StatusW-1:0] status_r;
  logic [DslotW-1:0]  dslot_r;
  logic [HslotW-1:0]  hslot_r;
  logic               drained_r;

  assign key = {KEY_HALF_BITS'(layer_r[LW-1:0]), KEY_HALF_BITS'(expert_r[LW-1:0])};

  // Shared scanner, sized to the larger slot group
  scan_ctl_t     sctl;
  logic [SW-1:0] sidx, sbest;
  logic          sdone, scur_valid;
  logic [StampW-1:0] scur_stamp;
  logic [SW:0]   scan_n_r;

  always_comb begin
    scur_valid = 1'b1;
    scur_stamp = '0;
    if ({1'b0, sidx} >= scan_n_r) begin
      scur_valid = 1'b1;
      scur_stamp = '1;
    end else if (hscan_r) begin
      scur_valid = hvalid_r[sidx[HW-1:0]];
      scur_stamp = hstamp_r[sidx[HW-1:0]];
    end else begin
      scur_valid = dvalid_r[sidx[DW-1:0]];
      scur_stamp = dstamp_r[sidx[DW-1:0]];
    end
  end

  tllsp_lru_scan #(.N(1 << SW), .IW(SW)) u_scan (
    .clk, .rst_n, .ctl(sctl), .cur_valid(scur_valid), .cur_stamp(scur_stamp),
    .idx(sidx), .done(sdone), .best(sbest)
  );

  logic [BytesW-1:0] cap;
  assign cap = (sbytes_r == '0) ? ebytes_r : sbytes_r;

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    sctl.start = 1'b0;
    if (state_r == S_CHECK) sctl.start = 1'b1;
    if (state_r == S_HWAIT) sctl.start = 1'b1;
  end

  logic pmatch, dmatch;
  assign pmatch = (pkey_r[pidx_r] == key);
  assign dmatch = dvalid_r[hidx_r] && (dkey_r[hidx_r] == key);

  // Sequencer: hold state, slot tables and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      layers_r  <= CntCfgW'(1);
      experts_r <= CntCfgW'(1);
      ebytes_r  <= BytesW'(1);
      sbytes_r  <= '0;
      dvalid_r  <= '0;
      hvalid_r  <= '0;
      hlive_r   <= '0;
      pfill_r   <= '0;
      stamp_r   <= '0;
      hits_r    <= '0;
      misses_r  <= '0;
      out_valid <= 1'b0;
      hscan_r   <= 1'b0;
      scan_n_r  <= '0;
      for (int i = 0; i < DEV_SLOT_NUM; i++) begin
        dkey_r[i]   <= '0;
        dstamp_r[i] <= '0;
      end
      for (int i = 0; i < HOST_SLOT_NUM; i++) hstamp_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LAYERS:  layers_r  <= cfg_data[CntCfgW-1:0];
          CFG_EXPERTS: experts_r <= cfg_data[CntCfgW-1:0];
          CFG_EBYTES:  ebytes_r  <= cfg_data;
          CFG_SBYTES:  sbytes_r  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r    <= in_func;
            layer_r   <= in_layer_index;
            expert_r  <= in_expert_index;
            pidx_r    <= '0;
            hidx_r    <= '0;
            found_r   <= 1'b0;
            drained_r <= 1'b0;
            dslot_r   <= '0;
            hslot_r   <= '0;
            status_r  <= ST_RANGE;
            unique case (in_func)
              FUNC_DRAIN: begin
                pfill_r  <= '0;
                hlive_r  <= '0;
                status_r <= ST_DONE;
                state_r  <= S_OUT;
                out_valid <= 1'b1;
              end
              FUNC_LOCATE: state_r <= S_HITSCAN;
              FUNC_STAGE:  state_r <= S_PEND;
              default: begin
                state_r   <= S_OUT;
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        // Check one pending entry per cycle
        S_PEND: begin
          if (PW'(pidx_r) >= pfill_r) state_r <= S_HITSCAN;
          else if (pmatch) begin
            status_r  <= ST_OVERLAP;
            state_r   <= S_OUT;
            out_valid <= 1'b1;
          end else if (pidx_r == HW'(HOST_SLOT_NUM - 1)) state_r <= S_HITSCAN;
          else pidx_r <= pidx_r + 1'b1;
        end
        // Look for the key in the device slots, lowest first
        S_HITSCAN: begin
          if (dmatch) begin
            found_r <= 1'b1;
            dslot_r <= DslotW'(hidx_r);
            state_r <= S_CHECK;
          end else if (hidx_r == DW'(DEV_SLOT_NUM - 1)) state_r <= S_CHECK;
          else hidx_r <= hidx_r + 1'b1;
        end
        S_CHECK: begin
          hscan_r  <= 1'b1;
          scan_n_r <= (SW+1)'(HOST_SLOT_NUM);
          if (func_r == FUNC_LOCATE) begin
            status_r  <= found_r ? ST_HIT : ST_NOTRES;
            state_r   <= S_OUT;
            out_valid <= 1'b1;
          end else if (found_r) begin
            stamp_r          <= stamp_r + 1'b1;
            dstamp_r[hidx_r] <= stamp_r + 1'b1;
            if (hits_r != '1) hits_r <= hits_r + 1'b1;
            status_r  <= ST_HIT;
            state_r   <= S_OUT;
            out_valid <= 1'b1;
          end else if (ebytes_r > cap) begin
            status_r  <= ST_SMALL;
            state_r   <= S_OUT;
            out_valid <= 1'b1;
          end else if ({1'b0, layer_r} >= layers_r || {1'b0, expert_r} >= experts_r) begin
            status_r  <= ST_RANGE;
            state_r   <= S_OUT;
            out_valid <= 1'b1;
          end else state_r <= S_HSCAN;
        end
        // Host LRU scan
        S_HSCAN: begin
          if (sdone) begin
            hsel_r  <= sbest[HW-1:0];
            state_r <= S_HWAIT;
          end
        end
        S_HWAIT: begin
          if (hlive_r[hsel_r]) begin
            hlive_r   <= '0;
            pfill_r   <= '0;
            drained_r <= 1'b1;
          end
          stamp_r          <= stamp_r + 1'b1;
          hvalid_r[hsel_r] <= 1'b1;
          hstamp_r[hsel_r] <= stamp_r + 1'b1;
          hscan_r  <= 1'b0;
          scan_n_r <= (SW+1)'(DEV_SLOT_NUM);
          state_r  <= S_DSCAN;
        end
        // Device LRU scan, then fill
        S_DSCAN: begin
          if (sdone) begin
            dkey_r[sbest[DW-1:0]]   <= key;
            dvalid_r[sbest[DW-1:0]] <= 1'b1;
            dstamp_r[sbest[DW-1:0]] <= stamp_r;
            if (pfill_r < PW'(HOST_SLOT_NUM)) begin
              pkey_r[pfill_r[HW-1:0]] <= key;
              pfill_r <= pfill_r + 1'b1;
            end
            hlive_r[hsel_r] <= 1'b1;
            if (misses_r != '1) misses_r <= misses_r + 1'b1;
            status_r  <= ST_MISS;
            dslot_r   <= DslotW'(sbest[DW-1:0]);
            hslot_r   <= HslotW'(hsel_r);
            state_r   <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          state_r   <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_status            = status_r;
  assign out_device_slot_index = dslot_r;
  assign out_host_slot_index   = hslot_r;
  assign out_drained           = drained_r;
  assign out_pending_count     = PendW'(pfill_r);
  assign out_hit_total         = hits_r;
  assign out_miss_total        = misses_r;

  // Result only shown in the output state
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result outside output state");
  // Pending fill never exceeds host slots
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    pfill_r <= PW'(HOST_SLOT_NUM)) else $error("pending overflow");
  // A drain request empties the pending list
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == FUNC_DRAIN |=> pfill_r == '0 && hlive_r == '0)
    else $error("drain left pending");

endmodule

// File: tb/sv/tb_two_level_lru_slot_pager_unit.sv
// Self-checking testbench for the two-level LRU slot pager unit.
`timescale 1ns / 100ps

module tb_two_level_lru_slot_pager_unit;
  import tllsp_pkg::*;

  localparam int NHOST = HostSlotsDef;
  localparam int NDEV  = DeviceSlotsDef;
  localparam int HALF  = KeyHalfDef;
  localparam int LIMIT_CYCLES = 1500000;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [DslotW-1:0]  dslot;
    logic [HslotW-1:0]  hslot;
    logic               drained;
    logic [PendW-1:0]   pending;
    logic [CountW-1:0]  hits;
    logic [CountW-1:0]  misses;
  } pager_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FuncW-1:0] in_func = '0;
  logic [IdxW-1:0] in_layer_index = '0;
  logic [IdxW-1:0] in_expert_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [StatusW-1:0] out_status;
  logic [DslotW-1:0] out_device_slot_index;
  logic [HslotW-1:0] out_host_slot_index;
  logic out_drained;
  logic [PendW-1:0] out_pending_count;
  logic [CountW-1:0] out_hit_total;
  logic [CountW-1:0] out_miss_total;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [BytesW-1:0] cfg_data = '0;

  two_level_lru_slot_pager_unit dut (.*);

  always #5 clk = ~clk;

  // Predictor copy of the pager state
  logic [CntCfgW-1:0] layers_cfg;
  logic [CntCfgW-1:0] experts_cfg;
  logic [BytesW-1:0] ebytes_cfg;
  logic [BytesW-1:0] sbytes_cfg;
  logic [2*HALF-1:0] dev_key [NDEV];
  logic dev_valid [NDEV];
  logic [StampW-1:0] dev_stamp [NDEV];
  logic host_valid [NHOST];
  logic [StampW-1:0] host_stamp [NHOST];
  logic host_inuse [NHOST];
  logic [2*HALF-1:0] pend_key [NHOST];
  int pend_fill;
  logic [StampW-1:0] stamp_ctr;
  logic [CountW-1:0] hit_ctr;
  logic [CountW-1:0] miss_ctr;

  pager_result_t expected_results [$];
  int cycle_count = 0;
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int miss_seen = 0;
  int drained_seen = 0;
  int out_wait_left = 0;
  logic stall_random = 1'b1;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_two_level_lru_slot_pager_unit failed");
      $finish;
    end
  end

  task automatic reset_model();
    layers_cfg = CntCfgW'(1);
    experts_cfg = CntCfgW'(1);
    ebytes_cfg = BytesW'(1);
    sbytes_cfg = '0;
    for (int i = 0; i < NDEV; i++) begin
      dev_key[i] = '0;
      dev_valid[i] = 1'b0;
      dev_stamp[i] = '0;
    end
    for (int i = 0; i < NHOST; i++) begin
      host_valid[i] = 1'b0;
      host_stamp[i] = '0;
      host_inuse[i] = 1'b0;
      pend_key[i] = '0;
    end
    pend_fill = 0;
    stamp_ctr = '0;
    hit_ctr = '0;
    miss_ctr = '0;
  endtask

  function automatic int find_resident(logic [2*HALF-1:0] key);
    for (int i = 0; i < NDEV; i++)
      if (dev_valid[i] && dev_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int lru_host();
    int best;
    best = 0;
    for (int i = 0; i < NHOST; i++) if (!host_valid[i]) return i;
    for (int i = 1; i < NHOST; i++) if (host_stamp[i] < host_stamp[best]) best = i;
    return best;
  endfunction

  function automatic int lru_device();
    int best;
    best = 0;
    for (int i = 0; i < NDEV; i++) if (!dev_valid[i]) return i;
    for (int i = 1; i < NDEV; i++) if (dev_stamp[i] < dev_stamp[best]) best = i;
    return best;
  endfunction

  // Work out the result of one request and advance the model
  function automatic pager_result_t page_request(logic [FuncW-1:0] f, logic [IdxW-1:0] lay,
                                                 logic [IdxW-1:0] exp_i);
    pager_result_t r;
    logic [2*HALF-1:0] key;
    logic [BytesW-1:0] cap;
    logic overlap;
    int d, h, v;
    r = '0;
    r.status = ST_RANGE;
    key = {lay, exp_i};
    if (f == FUNC_DRAIN) begin
      pend_fill = 0;
      for (int i = 0; i < NHOST; i++) host_inuse[i] = 1'b0;
      r.status = ST_DONE;
    end else if (f == FUNC_LOCATE) begin
      d = find_resident(key);
      if (d >= 0) begin
        r.status = ST_HIT;
        r.dslot = d[DslotW-1:0];
      end else begin
        r.status = ST_NOTRES;
      end
    end else if (f == FUNC_STAGE) begin
      cap = (sbytes_cfg != 0) ? sbytes_cfg : ebytes_cfg;
      overlap = 1'b0;
      for (int i = 0; i < pend_fill; i++) if (pend_key[i] == key) overlap = 1'b1;
      d = overlap ? -1 : find_resident(key);
      if (overlap) begin
        r.status = ST_OVERLAP;
      end else if (d >= 0) begin
        stamp_ctr = stamp_ctr + 1;
        dev_stamp[d] = stamp_ctr;
        if (hit_ctr != '1) hit_ctr = hit_ctr + 1;
        r.status = ST_HIT;
        r.dslot = d[DslotW-1:0];
      end else if (ebytes_cfg > cap) begin
        r.status = ST_SMALL;
      end else if ({1'b0, lay} >= layers_cfg || {1'b0, exp_i} >= experts_cfg) begin
        r.status = ST_RANGE;
      end else begin
        h = lru_host();
        if (host_inuse[h]) begin
          pend_fill = 0;
          for (int i = 0; i < NHOST; i++) host_inuse[i] = 1'b0;
          r.drained = 1'b1;
        end
        stamp_ctr = stamp_ctr + 1;
        host_valid[h] = 1'b1;
        host_stamp[h] = stamp_ctr;
        v = lru_device();
        dev_key[v] = key;
        dev_valid[v] = 1'b1;
        dev_stamp[v] = stamp_ctr;
        if (pend_fill < NHOST) begin
          pend_key[pend_fill] = key;
          pend_fill++;
        end
        host_inuse[h] = 1'b1;
        if (miss_ctr != '1) miss_ctr = miss_ctr + 1;
        r.status = ST_MISS;
        r.dslot = v[DslotW-1:0];
        r.hslot = h[HslotW-1:0];
      end
    end
    r.pending = pend_fill[PendW-1:0];
    r.hits = hit_ctr;
    r.misses = miss_ctr;
    return r;
  endfunction

  // Send one request after a random gap and predict its result
  task automatic send_request(logic [FuncW-1:0] f, logic [IdxW-1:0] lay,
                              logic [IdxW-1:0] exp_i);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func <= f;
    in_layer_index <= lay;
    in_expert_index <= exp_i;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_results.insert(expected_results.size(), page_request(f, lay, exp_i));
    requests_sent++;
    @(negedge clk);
  endtask

  // Hold each result for a randomly drawn number of cycles
  always @(negedge clk) begin
    if (out_valid && out_wait_left > 0) begin
      out_stall <= 1'b1;
      out_wait_left <= out_wait_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!out_valid) out_wait_left <= stall_random ? $urandom_range(0, 5) : 0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    pager_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_device_slot_index, out_host_slot_index, out_drained,
             out_pending_count, out_hit_total, out_miss_total};
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got.status == ST_MISS) miss_seen++;
        if (got.drained) drained_seen++;
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: status %0d/%0d dslot %0d/%0d hslot %0d/%0d",
                     results_seen, want.status, got.status, want.dslot, got.dslot,
                     want.hslot, got.hslot, " drained %0d/%0d pend %0d/%0d",
                     want.drained, got.drained, want.pending, got.pending,
                     " hits %0d/%0d misses %0d/%0d",
                     want.hits, got.hits, want.misses, got.misses);
        end
      end
    end
  end

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (NHOST + 2 * NDEV + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [BytesW-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LAYERS:  layers_cfg = value[CntCfgW-1:0];
      CFG_EXPERTS: experts_cfg = value[CntCfgW-1:0];
      CFG_EBYTES:  ebytes_cfg = value;
      default:     sbytes_cfg = value;
    endcase
    @(negedge clk);
  endtask

  task automatic set_geometry(int lay, int exps, logic [BytesW-1:0] eb, logic [BytesW-1:0] sb);
    wait_idle();
    write_register(CFG_LAYERS, BytesW'(lay));
    write_register(CFG_EXPERTS, BytesW'(exps));
    write_register(CFG_EBYTES, eb);
    write_register(CFG_SBYTES, sb);
    cfg_valid <= 1'b0;
  endtask

  // Reset defaults: only key 0/0 fits, then directed corners
  task automatic test_directed();
    send_request(FUNC_LOCATE, '0, '0);
    send_request(FUNC_STAGE, '0, '0);
    send_request(FUNC_STAGE, '0, '0);
    send_request(FUNC_LOCATE, '0, '0);
    send_request(FUNC_STAGE, 8'hff, 8'hff);
    send_request(FUNC_RSVD, 8'h12, 8'h34);
    send_request(FUNC_DRAIN, '0, '0);
    send_request(FUNC_STAGE, '0, '0);
    set_geometry(256, 256, 40'hff_ffff_ffff, 40'hff_ffff_fffe);
    send_request(FUNC_STAGE, 8'h01, 8'h01);
    set_geometry(256, 256, 40'hff_ffff_ffff, '0);
    // fill host slots so the fifth miss forces an implicit drain
    for (int i = 1; i <= 6; i++) send_request(FUNC_STAGE, 8'hff, i[7:0]);
    send_request(FUNC_STAGE, 8'hff, 8'h01);
    send_request(FUNC_LOCATE, 8'hff, 8'h06);
    send_request(FUNC_STAGE, 8'hff, 8'h06);
    send_request(FUNC_LOCATE, 8'h55, 8'haa);
    send_request(FUNC_DRAIN, '0, '0);
  endtask

  // Overflow the device slots to exercise LRU eviction
  task automatic test_eviction();
    set_geometry(2, 16, 40'd100, 40'd100);
    for (int i = 0; i < 24; i++) begin
      send_request(FUNC_STAGE, IdxW'(i[4]), IdxW'(i[3:0] ^ 4'h5));
      if (i % 3 == 2) send_request(FUNC_DRAIN, '0, '0);
    end
  endtask

  // Random requests over a few settings, mostly keys inside a small range
  task automatic test_random(int count, int lay, int exps);
    logic [FuncW-1:0] f;
    logic [IdxW-1:0] l, e;
    int pick;
    set_geometry(lay, exps, BytesW'($urandom_range(1, 1000)),
                 BytesW'($urandom_range(0, 3) == 0 ? 0 : 1000));
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) f = FUNC_STAGE;
      else if (pick < 75) f = FUNC_DRAIN;
      else if (pick < 95) f = FUNC_LOCATE;
      else f = FUNC_RSVD;
      if ($urandom_range(0, 9) == 0) begin
        l = IdxW'($urandom_range(0, 255));
        e = IdxW'($urandom_range(0, 255));
      end else begin
        l = IdxW'($urandom_range(0, (lay > 256 ? 255 : lay - 1)));
        e = IdxW'($urandom_range(0, (exps > 256 ? 255 : exps - 1) < 7 ?
                                    (exps > 256 ? 255 : exps - 1) : 7));
      end
      stall_random = (n % 200) < 150;
      send_request(f, l, e);
    end
    stall_random = 1'b1;
  endtask

  initial begin
    reset_model();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_eviction();
    test_random(400, 4, 8);
    test_random(400, 3, 256);
    test_random(400, 256, 5);
    test_random(400, 1, 1);
    wait_idle();
    $display("sent %0d requests, checked %0d results", requests_sent, results_seen);
    $display("%0d misses, %0d implicit drains, %0d mismatches",
             miss_seen, drained_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_two_level_lru_slot_pager_unit passed");
    end else begin
      $display("tb_two_level_lru_slot_pager_unit failed");
    end
    $finish;
  end

endmodule
